@@ rtl/core/rhh_pkg.sv @@
// Package for the Robin Hood hash table: sizes, codes, slot layout and states.
// Used by the channel interfaces, the top level and its checker.
package rhh_pkg;
   localparam int SLOTS     = 1024;
   localparam int KEY_WIDTH = 64;
   localparam int ADDR_W    = $clog2(SLOTS);
   localparam int IDX_W     = ADDR_W + 1;
   localparam int CAP_W     = 10;
   localparam int PROBE_W   = 6;
   localparam int LOAD_W    = 11;
   localparam int COUNT_W   = 11;
   localparam int DIST_W    = 7;
   localparam int WORD_W    = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 11;
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = WORD_W / MOD_BITS;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   localparam logic [DIST_W-1:0] DIST_EMPTY = '1;

   localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(5);
   localparam logic [PROBE_W-1:0] PROBE_RESET = PROBE_W'(2);
   localparam logic [LOAD_W-1:0]  LOAD_RESET  = LOAD_W'(6);

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_ERASE  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_NEW    = 2'd0,
      ST_FOUND  = 2'd1,
      ST_ABSENT = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY = 2'd0,
      CSR_PROBE    = 2'd1,
      CSR_LOAD     = 2'd2,
      CSR_SPARE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIST_W-1:0]    distance;
      logic [KEY_WIDTH-1:0] key;
      logic [WORD_W-1:0]    hash;
      logic [WORD_W-1:0]    value;
   } slot_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_SEARCH_RD,
      S_SEARCH_EV,
      S_DRY_RD,
      S_DRY_EV,
      S_REAL_RD,
      S_REAL_EV,
      S_SHIFT_RD,
      S_SHIFT_EV,
      S_RESP
   } state_type;
endpackage

@@ rtl/core/rhh_req_if.sv @@
// Request channel: valid/ready beat carrying type, key, hash and value.
// Depends on rhh_pkg.
interface rhh_req_if import rhh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [KEY_WIDTH-1:0] key;
   logic [WORD_W-1:0]    key_hash;
   logic [WORD_W-1:0]    value;

   modport source (output valid, req_type, key, key_hash, value, input ready);
   modport sink   (input valid, req_type, key, key_hash, value, output ready);
endinterface

@@ rtl/core/rhh_rsp_if.sv @@
// Response channel: valid/ready beat carrying status, value and entry count.
// Depends on rhh_pkg.
interface rhh_rsp_if import rhh_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [WORD_W-1:0]  found_value;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, status, found_value, entry_count, input ready);
   modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

@@ rtl/core/robin_hood_hash_table.sv @@
// Robin Hood hash table: slot memory, modulo unit and probe sequencer.
// Depends on rhh_pkg, rhh_req_if and rhh_rsp_if.
//
// One request is handled at a time. After reset a clearing pass marks every
// slot empty; no request beat is taken during it. A request then reduces the
// hash modulo the capacity (4 bits a cycle), and reads and evaluates each slot
// visited, since each slot is read from the single-port-read slot memory and
// evaluated in the next cycle. An insert walks the search run, then a check pass
// and a placement pass over the displacement chain; an erase shifts back each
// following entry of the run in turn, up to the slot that ends it. Requests of
// unused type or over the load limit go straight to the response. A finished
// response waits in an output register.
module robin_hood_hash_table import rhh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rhh_req_if.sink              req_chan,
   rhh_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);
   slot_type mem [SLOTS];

   state_type            state_ff, state_in;
   logic [CAP_W-1:0]     cap_ff;
   logic [PROBE_W-1:0]   probe_ff;
   logic [LOAD_W-1:0]    load_ff;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [1:0]           op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [WORD_W-1:0]    hash_ff, hash_in;
   logic [WORD_W-1:0]    val_ff, val_in;
   logic [WORD_W-1:0]    sh_ff, sh_in;
   logic [CAP_W-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     home_ff, home_in;
   logic [7:0]           d_ff, d_in;
   logic [7:0]           dsave_ff, dsave_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   status_type           st_ff, st_in;
   logic [WORD_W-1:0]    fval_ff, fval_in;
   logic                 ov_ff, ov_in;
   status_type           ost_ff;
   logic [WORD_W-1:0]    ofval_ff;
   logic [COUNT_W-1:0]   ocount_ff;
   slot_type             rd_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   slot_type          mem_wdata;

   logic [CAP_W-1:0] cap_eff;
   logic [CAP_W-1:0] rem_step;
   logic             oob, empty, match, out_free, accept;

   assign cap_eff  = (cap_ff == '0) ? CAP_W'(1) : cap_ff;
   assign oob      = idx_ff[IDX_W-1];
   assign empty    = rd_ff.distance == DIST_EMPTY;
   assign match    = (rd_ff.key == key_ff) && (rd_ff.hash == hash_ff);
   assign out_free = !ov_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;

   assign req_chan.ready       = state_ff == S_IDLE;
   assign rsp_chan.valid       = ov_ff;
   assign rsp_chan.status      = ost_ff;
   assign rsp_chan.found_value = ofval_ff;
   assign rsp_chan.entry_count = ocount_ff;

   // remainder, four hash bits per cycle, most significant first
   always_comb begin
      logic [CAP_W:0] r;
      r = {1'b0, rem_ff};
      for (int k = 0; k < MOD_BITS; k++) begin
         r = {r[CAP_W-1:0], sh_ff[WORD_W-1-k]};
         if (r >= {1'b0, cap_eff}) begin
            r = r - {1'b0, cap_eff};
         end
      end
      rem_step = r[CAP_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (clr_ff == ADDR_W'(SLOTS - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (req_chan.req_type == REQ_NONE) begin
                  state_in = S_RESP;
               end else if (req_chan.req_type == REQ_INSERT &&
                            ({1'b0, count_ff} + 12'd1) > {1'b0, load_ff}) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD:       if (step_ff == STEP_W'(MOD_STEPS - 1)) state_in = S_SEARCH_RD;
         S_SEARCH_RD: state_in = S_SEARCH_EV;
         S_SEARCH_EV: begin
            if (oob || empty || {1'b0, rd_ff.distance} < d_ff) begin
               state_in = (op_ff == REQ_INSERT) ? S_DRY_RD : S_RESP;
            end else if (match) begin
               state_in = (op_ff == REQ_ERASE) ? S_SHIFT_RD : S_RESP;
            end else begin
               state_in = S_SEARCH_RD;
            end
         end
         S_DRY_RD:    state_in = S_DRY_EV;
         S_DRY_EV: begin
            if (oob || d_ff >= {2'b0, probe_ff}) state_in = S_RESP;
            else if (empty) state_in = S_REAL_RD;
            else state_in = S_DRY_RD;
         end
         S_REAL_RD:   state_in = S_REAL_EV;
         S_REAL_EV:   state_in = empty ? S_RESP : S_REAL_RD;
         S_SHIFT_RD:  state_in = S_SHIFT_EV;
         S_SHIFT_EV: begin
            if (!oob && !empty && rd_ff.distance != '0) state_in = S_SHIFT_RD;
            else state_in = S_RESP;
         end
         S_RESP:      if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      clr_in   = clr_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      hash_in  = hash_ff;
      val_in   = val_ff;
      sh_in    = sh_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      home_in  = home_ff;
      d_in     = d_ff;
      dsave_in = dsave_ff;
      count_in = count_ff;
      st_in    = st_ff;
      fval_in  = fval_ff;
      ov_in    = ov_ff && !rsp_chan.ready;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[ADDR_W-1:0];
      mem_wdata = '{distance: d_ff[DIST_W-1:0], key: key_ff, hash: hash_ff, value: val_ff};
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '{distance: DIST_EMPTY, default: '0};
            clr_in    = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (accept) begin
               op_in   = req_chan.req_type;
               key_in  = req_chan.key;
               hash_in = req_chan.key_hash;
               val_in  = req_chan.value;
               sh_in   = req_chan.key_hash;
               rem_in  = '0;
               step_in = '0;
               fval_in = '0;
               st_in   = (req_chan.req_type == REQ_INSERT) ? ST_FULL : ST_ABSENT;
            end
         end
         S_MOD: begin
            rem_in  = rem_step;
            sh_in   = sh_ff << MOD_BITS;
            step_in = step_ff + STEP_W'(1);
            idx_in  = {1'b0, rem_step};
            d_in    = '0;
         end
         S_SEARCH_EV: begin
            if (oob || empty || {1'b0, rd_ff.distance} < d_ff) begin
               home_in  = idx_ff;
               dsave_in = d_ff;
               st_in    = ST_ABSENT;
            end else if (match) begin
               st_in   = ST_FOUND;
               fval_in = rd_ff.value;
               idx_in  = idx_ff + IDX_W'(1);
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               d_in   = d_ff + 8'd1;
            end
         end
         S_DRY_EV: begin
            if (oob || d_ff >= {2'b0, probe_ff}) begin
               st_in = ST_FULL;
            end else if (empty) begin
               idx_in = home_ff;
               d_in   = dsave_ff;
            end else begin
               d_in   = ({1'b0, rd_ff.distance} < d_ff) ?
                        {1'b0, rd_ff.distance} + 8'd1 : d_ff + 8'd1;
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_REAL_EV: begin
            if (empty) begin
               mem_we   = 1'b1;
               count_in = count_ff + COUNT_W'(1);
               st_in    = ST_NEW;
            end else if ({1'b0, rd_ff.distance} < d_ff) begin
               mem_we  = 1'b1;
               key_in  = rd_ff.key;
               hash_in = rd_ff.hash;
               val_in  = rd_ff.value;
               d_in    = {1'b0, rd_ff.distance} + 8'd1;
               idx_in  = idx_ff + IDX_W'(1);
            end else begin
               d_in   = d_ff + 8'd1;
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_SHIFT_EV: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[ADDR_W-1:0] - ADDR_W'(1);
            if (!oob && !empty && rd_ff.distance != '0) begin
               mem_wdata          = rd_ff;
               mem_wdata.distance = rd_ff.distance - DIST_W'(1);
               idx_in             = idx_ff + IDX_W'(1);
            end else begin
               mem_wdata = '{distance: DIST_EMPTY, key: key_ff, hash: hash_ff, value: val_ff};
               if (count_ff != '0) count_in = count_ff - COUNT_W'(1);
            end
         end
         S_RESP: begin
            if (out_free) ov_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
         ov_ff    <= 1'b0;
         cap_ff   <= CAP_RESET;
         probe_ff <= PROBE_RESET;
         load_ff  <= LOAD_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff   <= csr_data[CAP_W-1:0];
               CSR_PROBE:    probe_ff <= csr_data[PROBE_W-1:0];
               CSR_LOAD:     load_ff  <= csr_data[LOAD_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      hash_ff  <= hash_in;
      val_ff   <= val_in;
      sh_ff    <= sh_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      idx_ff   <= idx_in;
      home_ff  <= home_in;
      d_ff     <= d_in;
      dsave_ff <= dsave_in;
      st_ff    <= st_in;
      fval_ff  <= fval_in;
      if (state_ff == S_RESP && out_free) begin
         ost_ff    <= st_ff;
         ofval_ff  <= fval_ff;
         ocount_ff <= count_ff;
      end
   end
endmodule

@@ rtl/core/rhh_checker.sv @@
// Port-level checks for the Robin Hood hash table, bound to the top level.
// Depends on rhh_pkg.
module rhh_checker import rhh_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [WORD_W-1:0]  rsp_found_value,
   input logic [COUNT_W-1:0] rsp_entry_count
);
   a_value_only_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FOUND |-> rsp_found_value == '0)
      else $error("value returned without a hit");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= COUNT_W'(SLOTS))
      else $error("entry count beyond store");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("beat possible during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && !rsp_ready) && !$past(reset) |->
         rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("stalled response changed");
endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_found_value (rsp_chan.found_value),
   .rsp_entry_count (rsp_chan.entry_count)
);

@@ verif/testbench.sv @@
// Testbench for robin_hood_hash_table: random and directed requests with a checking model.
// Depends on rhh_pkg, rhh_req_if, rhh_rsp_if and the top level.
`timescale 1ns / 1ps

module testbench;
   import rhh_pkg::*;

   localparam int STALL_LIMIT = 30000;
   localparam int POOL_N      = 24;

   typedef struct {
      req_code_type      op;
      logic [63:0]       key;
      logic [63:0]       hash;
      logic [63:0]       value;
   } request_type;

   typedef struct {
      status_type         status;
      logic [63:0]        value;
      logic [COUNT_W-1:0] count;
   } answer_type;

   class hash_table_scoreboard;
      logic [63:0]        tbl_key [SLOTS];
      logic [63:0]        tbl_hash[SLOTS];
      logic [63:0]        tbl_val [SLOTS];
      logic [DIST_W-1:0]  tbl_dist[SLOTS];
      int unsigned        n_stored;
      int unsigned        cap, probe, load;
      answer_type         awaited[$];
      int                 errors;

      function void clear();
         foreach (tbl_dist[i]) tbl_dist[i] = DIST_EMPTY;
         n_stored = 0;
         cap = CAP_RESET;
         probe = PROBE_RESET;
         load = LOAD_RESET;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, int unsigned data);
         case (idx)
            CSR_CAPACITY: cap = data & 'h3ff;
            CSR_PROBE:    probe = data & 'h3f;
            CSR_LOAD:     load = data & 'h7ff;
            default: ;
         endcase
      endfunction

      function int unsigned home_of(logic [63:0] h);
         int unsigned c;
         c = (cap == 0) ? 1 : cap;
         return int'(h % 64'(c));
      endfunction

      function bit held(int unsigned i);
         return tbl_dist[i] != DIST_EMPTY;
      endfunction

      function int unsigned locate(logic [63:0] k, logic [63:0] h);
         int unsigned i, d;
         i = home_of(h);
         d = 0;
         while (i < SLOTS && held(i) && tbl_dist[i] >= d) begin
            if (tbl_hash[i] == h && tbl_key[i] == k) return i;
            i++;
            d++;
         end
         return SLOTS;
      endfunction

      function status_type place(logic [63:0] k, logic [63:0] h, logic [63:0] v,
                                 output logic [63:0] hit);
         int unsigned i, d, j, c, td;
         logic [63:0] tk, th, tv;
         hit = '0;
         if (n_stored + 1 > load) return ST_FULL;
         i = home_of(h);
         d = 0;
         while (i < SLOTS && held(i) && tbl_dist[i] >= d) begin
            if (tbl_hash[i] == h && tbl_key[i] == k) begin
               hit = tbl_val[i];
               return ST_FOUND;
            end
            i++;
            d++;
         end
         j = i;
         c = d;
         forever begin
            if (j >= SLOTS || c >= probe) return ST_FULL;
            if (!held(j)) break;
            if (tbl_dist[j] < c) c = tbl_dist[j] + 1;
            else c++;
            j++;
         end
         j = i;
         c = d;
         forever begin
            if (!held(j)) begin
               tbl_key[j] = k; tbl_val[j] = v; tbl_hash[j] = h;
               tbl_dist[j] = DIST_W'(c);
               break;
            end
            if (tbl_dist[j] < c) begin
               tk = tbl_key[j]; tv = tbl_val[j]; th = tbl_hash[j]; td = tbl_dist[j];
               tbl_key[j] = k; tbl_val[j] = v; tbl_hash[j] = h;
               tbl_dist[j] = DIST_W'(c);
               k = tk; v = tv; h = th; c = td + 1;
            end else begin
               c++;
            end
            j++;
         end
         n_stored++;
         return ST_NEW;
      endfunction

      function status_type remove(logic [63:0] k, logic [63:0] h, output logic [63:0] hit);
         int unsigned j;
         hit = '0;
         j = locate(k, h);
         if (j >= SLOTS) return ST_ABSENT;
         hit = tbl_val[j];
         while (j + 1 < SLOTS && held(j + 1) && tbl_dist[j + 1] > 0) begin
            tbl_key[j] = tbl_key[j + 1];
            tbl_val[j] = tbl_val[j + 1];
            tbl_hash[j] = tbl_hash[j + 1];
            tbl_dist[j] = tbl_dist[j + 1] - 1;
            j++;
         end
         tbl_dist[j] = DIST_EMPTY;
         if (n_stored > 0) n_stored--;
         return ST_FOUND;
      endfunction

      function void note_request(request_type rq);
         answer_type  a;
         logic [63:0] hit;
         int unsigned j;
         hit = '0;
         a.status = ST_ABSENT;
         case (rq.op)
            REQ_INSERT: a.status = place(rq.key, rq.hash, rq.value, hit);
            REQ_LOOKUP: begin
               j = locate(rq.key, rq.hash);
               if (j < SLOTS) begin
                  a.status = ST_FOUND;
                  hit = tbl_val[j];
               end
            end
            REQ_ERASE: a.status = remove(rq.key, rq.hash, hit);
            default: ;
         endcase
         a.value = (a.status == ST_FOUND) ? hit : '0;
         a.count = COUNT_W'(n_stored);
         awaited.push_back(a);
      endfunction

      function void fail(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_response(logic [1:0] st, logic [63:0] v, logic [COUNT_W-1:0] n);
         answer_type a;
         if (awaited.size() == 0) begin
            fail($sformatf("response with none due: status %0d", st));
            return;
         end
         a = awaited.pop_front();
         if (st !== a.status)
            fail($sformatf("status exp %0d got %0d", a.status, st));
         if (v !== a.value)
            fail($sformatf("found_value exp %h got %h", a.value, v));
         if (n !== a.count)
            fail($sformatf("entry_count exp %0d got %0d", a.count, n));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   rhh_req_if req_if ();
   rhh_rsp_if rsp_if ();

   robin_hood_hash_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   hash_table_scoreboard sb = new();

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.req_type = '0;
      req_if.key = '0;
      req_if.key_hash = '0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
   end

   // receiver stall pattern
   int stall_pct = 0;
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_request('{req_code_type'(req_if.req_type), req_if.key,
                           req_if.key_hash, req_if.value});
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.status, rsp_if.found_value, rsp_if.entry_count);
   end

   int quiet = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   int          burst_left = 0;
   int          max_gap = 0;
   logic [63:0] pool_key [POOL_N];
   logic [63:0] pool_hash[POOL_N];

   // called at a falling edge; returns at a falling edge after the beat
   task automatic send(req_code_type op, logic [63:0] k, logic [63:0] h, logic [63:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= op;
      req_if.key <= k;
      req_if.key_hash <= h;
      req_if.value <= v;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_reg(csr_index_type idx, int unsigned data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_W'(data);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] make_hash(int unsigned lo, int unsigned hi);
      logic [63:0] c;
      c = (sb.cap == 0) ? 64'd1 : 64'(sb.cap);
      return 64'($urandom_range(lo, hi)) + c * 64'($urandom_range(0, 1 << 20));
   endfunction

   task automatic run_phase(int unsigned cap, int unsigned probe, int unsigned load,
                            int unsigned lo, int unsigned hi, int n, int stall, int gap);
      int          r, p;
      logic [63:0] k, h;
      req_code_type op;
      drain();
      set_reg(CSR_CAPACITY, cap);
      set_reg(CSR_PROBE, probe);
      set_reg(CSR_LOAD, load);
      stall_pct = stall;
      max_gap = gap;
      for (int i = 0; i < POOL_N; i++) begin
         pool_key[i] = {$urandom, $urandom};
         if (i % 2 == 1 && $urandom_range(0, 1) == 1) pool_hash[i] = pool_hash[i - 1];
         else pool_hash[i] = make_hash(lo, hi);
      end
      repeat (n) begin
         r = $urandom_range(0, 99);
         op = (r < 45) ? REQ_INSERT : (r < 75) ? REQ_LOOKUP : (r < 95) ? REQ_ERASE : REQ_NONE;
         if ($urandom_range(0, 9) == 0) begin
            k = {$urandom, $urandom};
            h = {$urandom, $urandom};
         end else begin
            p = $urandom_range(0, POOL_N - 1);
            k = pool_key[p];
            h = pool_hash[p];
         end
         send(op, k, h, {$urandom, $urandom});
      end
   endtask

   initial begin
      sb.clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: capacity 5, probe limit 2, load limit 6
      stall_pct = 0;
      send(REQ_INSERT, 64'h11, 64'd0, 64'hA1);
      send(REQ_INSERT, 64'h11, 64'd0, 64'hFF);
      send(REQ_LOOKUP, 64'h11, 64'd0, 64'h0);
      send(REQ_INSERT, 64'h22, 64'd0, 64'hA2);
      send(REQ_INSERT, 64'h33, 64'd5, 64'hA3);
      send(REQ_LOOKUP, 64'h22, 64'd0, 64'h0);
      send(REQ_LOOKUP, 64'h22, 64'd5, 64'h0);
      send(REQ_ERASE, 64'h11, 64'd0, 64'h0);
      send(REQ_LOOKUP, 64'h22, 64'd0, 64'h0);
      send(REQ_ERASE, 64'h44, 64'd0, 64'h0);
      send(REQ_NONE, '1, '1, '1);
      send(REQ_INSERT, '1, '1, '1);
      send(REQ_LOOKUP, '1, '1, '0);
      send(REQ_INSERT, '0, 64'd1, '0);
      send(REQ_INSERT, 64'h55, 64'd2, 64'hA5);
      send(REQ_INSERT, 64'h66, 64'd3, 64'hA6);
      send(REQ_INSERT, 64'h77, 64'd4, 64'hA7);
      send(REQ_INSERT, 64'h88, 64'd2, 64'hA8);
      send(REQ_LOOKUP, '0, 64'd1, '0);
      send(REQ_ERASE, '1, '1, '0);
      send(REQ_ERASE, 64'h22, 64'd0, 64'h0);

      run_phase(2, 63, 1024, 0, 1, 150, 0, 0);
      run_phase(1023, 63, 1024, 1000, 1022, 150, 30, 4);
      run_phase(0, 3, 1, 0, 0, 60, 60, 8);
      run_phase(960, 8, 300, 900, 959, 200, 10, 2);
      run_phase(17, 5, 40, 0, 16, 200, 50, 6);
      run_phase(64, 63, 1024, 0, 7, 240, 20, 3);

      drain();
      repeat (200) @(negedge clock);
      if (sb.awaited.size() != 0) sb.fail("responses still due at end");
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
